FILE: rtl/pse_pkg.sv
package pse_pkg;

  // Input characters that act as operators, and the digit zero that offsets pushed values.
  localparam logic [7:0] CH_ADD  = 8'h2B;
  localparam logic [7:0] CH_SUB  = 8'h2D;
  localparam logic [7:0] CH_MUL  = 8'h2A;
  localparam logic [7:0] CH_DIV  = 8'h2F;
  localparam logic [7:0] CH_REM  = 8'h25;
  localparam logic [7:0] CH_ZERO = 8'h30;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_DIVZERO  = 2'd3;

  typedef logic [3:0] step_t;

  localparam step_t S_WAIT      = 4'd0;
  localparam step_t S_DECODE    = 4'd1;
  localparam step_t S_UNDER_CHK = 4'd2;
  localparam step_t S_DZ_CHK    = 4'd3;
  localparam step_t S_OP_SEL    = 4'd4;
  localparam step_t S_ALU       = 4'd5;
  localparam step_t S_DIV_INIT  = 4'd6;
  localparam step_t S_DIV_STEP  = 4'd7;
  localparam step_t S_DIV_FIX   = 4'd8;
  localparam step_t S_WB        = 4'd9;
  localparam step_t S_PUSH_CHK  = 4'd10;
  localparam step_t S_PUSH      = 4'd11;
  localparam step_t S_ERR_UNDER = 4'd12;
  localparam step_t S_ERR_OVER  = 4'd13;
  localparam step_t S_ERR_DIVZ  = 4'd14;
  localparam step_t S_EMIT      = 4'd15;

  typedef enum logic [3:0] {
    UOP_NONE,
    UOP_FETCH,
    UOP_READ,
    UOP_ALU,
    UOP_DIV_INIT,
    UOP_DIV_STEP,
    UOP_DIV_FIX,
    UOP_WB_OP,
    UOP_PUSH,
    UOP_ERR_UNDER,
    UOP_ERR_OVER,
    UOP_ERR_DIVZ,
    UOP_EMIT
  } uop_t;

  typedef enum logic [3:0] {
    COND_ALWAYS,
    COND_NO_REQ,
    COND_OPERAND,
    COND_UNDER,
    COND_DIVZERO,
    COND_DIVREM,
    COND_DIV_BUSY,
    COND_FULL,
    COND_OUT_BUSY
  } cond_t;

  // One microinstruction: datapath operation, branch condition, and the
  // next step when the condition is true or false.
  typedef struct packed {
    uop_t  uop;
    cond_t cond;
    step_t jt;
    step_t jf;
  } ctrl_word_t;

  typedef struct packed {
    logic is_operand;
    logic under;
    logic full;
    logic divzero;
    logic divrem;
    logic div_last;
    logic out_busy;
  } flags_t;

  function automatic ctrl_word_t microcode(input step_t step);
    ctrl_word_t cw;
    case (step)
      S_WAIT:      cw = '{UOP_FETCH,     COND_NO_REQ,   S_WAIT,      S_DECODE};
      S_DECODE:    cw = '{UOP_NONE,      COND_OPERAND,  S_PUSH_CHK,  S_UNDER_CHK};
      S_UNDER_CHK: cw = '{UOP_READ,      COND_UNDER,    S_ERR_UNDER, S_DZ_CHK};
      S_DZ_CHK:    cw = '{UOP_NONE,      COND_DIVZERO,  S_ERR_DIVZ,  S_OP_SEL};
      S_OP_SEL:    cw = '{UOP_NONE,      COND_DIVREM,   S_DIV_INIT,  S_ALU};
      S_ALU:       cw = '{UOP_ALU,       COND_ALWAYS,   S_WB,        S_WB};
      S_DIV_INIT:  cw = '{UOP_DIV_INIT,  COND_ALWAYS,   S_DIV_STEP,  S_DIV_STEP};
      S_DIV_STEP:  cw = '{UOP_DIV_STEP,  COND_DIV_BUSY, S_DIV_STEP,  S_DIV_FIX};
      S_DIV_FIX:   cw = '{UOP_DIV_FIX,   COND_ALWAYS,   S_WB,        S_WB};
      S_WB:        cw = '{UOP_WB_OP,     COND_ALWAYS,   S_EMIT,      S_EMIT};
      S_PUSH_CHK:  cw = '{UOP_NONE,      COND_FULL,     S_ERR_OVER,  S_PUSH};
      S_PUSH:      cw = '{UOP_PUSH,      COND_ALWAYS,   S_EMIT,      S_EMIT};
      S_ERR_UNDER: cw = '{UOP_ERR_UNDER, COND_ALWAYS,   S_EMIT,      S_EMIT};
      S_ERR_OVER:  cw = '{UOP_ERR_OVER,  COND_ALWAYS,   S_EMIT,      S_EMIT};
      S_ERR_DIVZ:  cw = '{UOP_ERR_DIVZ,  COND_ALWAYS,   S_EMIT,      S_EMIT};
      S_EMIT:      cw = '{UOP_EMIT,      COND_OUT_BUSY, S_EMIT,      S_WAIT};
      default:     cw = '{UOP_NONE,      COND_ALWAYS,   S_WAIT,      S_WAIT};
    endcase
    return cw;
  endfunction

endpackage

FILE: rtl/pse_useq.sv
module pse_useq (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  pse_pkg::flags_t     flags,
  output pse_pkg::ctrl_word_t cw
);

  pse_pkg::step_t upc;
  pse_pkg::step_t upc_next;
  logic           taken;

  assign cw = pse_pkg::microcode(upc);

  always_comb begin
    case (cw.cond)
      pse_pkg::COND_ALWAYS:   taken = 1'b1;
      pse_pkg::COND_NO_REQ:   taken = !in_valid;
      pse_pkg::COND_OPERAND:  taken = flags.is_operand;
      pse_pkg::COND_UNDER:    taken = flags.under;
      pse_pkg::COND_DIVZERO:  taken = flags.divzero;
      pse_pkg::COND_DIVREM:   taken = flags.divrem;
      pse_pkg::COND_DIV_BUSY: taken = !flags.div_last;
      pse_pkg::COND_FULL:     taken = flags.full;
      pse_pkg::COND_OUT_BUSY: taken = flags.out_busy;
      default:                taken = 1'b1;
    endcase
    upc_next = taken ? cw.jt : cw.jf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= pse_pkg::S_WAIT;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

FILE: rtl/pse_divider.sv
module pse_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        init,
  input  logic        step_en,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic [31:0] quotient,
  output logic [31:0] remainder,
  output logic        last
);

  logic [31:0] dvsr;
  logic [5:0]  count;
  logic [32:0] trial;

  // Restoring division, one quotient bit per cycle while step_en is high, on unsigned magnitudes.
  assign trial = {remainder, quotient[31]} - {1'b0, dvsr};
  assign last  = (count == 6'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 6'd0;
    end else if (init) begin
      count <= 6'd32;
    end else if (step_en && count != 6'd0) begin
      count <= count - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (init) begin
      dvsr      <= divisor;
      quotient  <= dividend;
      remainder <= 32'd0;
    end else if (step_en) begin
      if (!trial[32]) begin
        remainder <= trial[31:0];
        quotient  <= {quotient[30:0], 1'b1};
      end else begin
        remainder <= {remainder[30:0], quotient[31]};
        quotient  <= {quotient[30:0], 1'b0};
      end
    end
  end

endmodule

FILE: rtl/pse_datapath.sv
module pse_datapath #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  pse_pkg::ctrl_word_t cw,
  input  logic                in_accept,
  input  logic [7:0]          symbol,
  output pse_pkg::flags_t     flags,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  top_value,
  output logic [4:0]          stack_depth,
  output logic [1:0]          status
);

  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  logic [31:0]   mem [STACK_DEPTH];
  logic [7:0]    sym;
  logic [DW-1:0] depth;
  logic [DW-1:0] below;
  logic [31:0]   tos;
  logic [31:0]   lhs;
  logic [31:0]   res;
  logic [1:0]    st;
  logic          lhs_neg;
  logic          rhs_neg;
  logic [31:0]   push_val;
  logic [31:0]   alu_out;
  logic [31:0]   div_quo;
  logic [31:0]   div_rem;
  logic          div_last;
  logic          is_op;
  logic          out_busy;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;

  assign below    = depth - DW'(2);
  assign lhs_neg  = lhs[31];
  assign rhs_neg  = tos[31];
  assign push_val = {{24{sym[7]}}, sym} - {24'd0, pse_pkg::CH_ZERO};
  assign out_busy = out_valid && out_stall;

  assign is_op = (sym == pse_pkg::CH_ADD) || (sym == pse_pkg::CH_SUB) ||
                 (sym == pse_pkg::CH_MUL) || (sym == pse_pkg::CH_DIV) ||
                 (sym == pse_pkg::CH_REM);

  always_comb begin
    flags.is_operand = !is_op;
    flags.under      = depth < DW'(2);
    flags.full       = depth == DW'(STACK_DEPTH);
    flags.divrem     = (sym == pse_pkg::CH_DIV) || (sym == pse_pkg::CH_REM);
    flags.divzero    = flags.divrem && (tos == 32'd0);
    flags.div_last   = div_last;
    flags.out_busy   = out_busy;
  end

  // The top of the stack is kept in tos; the left operand comes from memory.
  always_comb begin
    case (sym)
      pse_pkg::CH_ADD: alu_out = lhs + tos;
      pse_pkg::CH_SUB: alu_out = lhs - tos;
      default:         alu_out = lhs * tos;
    endcase
  end

  pse_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .init      (cw.uop == pse_pkg::UOP_DIV_INIT),
    .step_en   (cw.uop == pse_pkg::UOP_DIV_STEP),
    .dividend  (lhs_neg ? (32'd0 - lhs) : lhs),
    .divisor   (rhs_neg ? (32'd0 - tos) : tos),
    .quotient  (div_quo),
    .remainder (div_rem),
    .last      (div_last)
  );

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = below[AW-1:0];
    mem_wdata = res;
    case (cw.uop)
      pse_pkg::UOP_WB_OP: begin
        mem_we = 1'b1;
      end
      pse_pkg::UOP_PUSH: begin
        mem_we    = 1'b1;
        mem_waddr = depth[AW-1:0];
        mem_wdata = push_val;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cw.uop == pse_pkg::UOP_READ) begin
      lhs <= mem[below[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      sym <= symbol;
    end
    case (cw.uop)
      pse_pkg::UOP_ALU: begin
        res <= alu_out;
      end
      pse_pkg::UOP_DIV_FIX: begin
        if (sym == pse_pkg::CH_DIV) begin
          res <= (lhs_neg ^ rhs_neg) ? (32'd0 - div_quo) : div_quo;
        end else begin
          res <= lhs_neg ? (32'd0 - div_rem) : div_rem;
        end
      end
      pse_pkg::UOP_WB_OP: begin
        tos <= res;
        st  <= pse_pkg::ST_OK;
      end
      pse_pkg::UOP_PUSH: begin
        tos <= push_val;
        st  <= pse_pkg::ST_OK;
      end
      pse_pkg::UOP_ERR_UNDER: begin
        st <= pse_pkg::ST_UNDERFLOW;
      end
      pse_pkg::UOP_ERR_OVER: begin
        st <= pse_pkg::ST_OVERFLOW;
      end
      pse_pkg::UOP_ERR_DIVZ: begin
        st <= pse_pkg::ST_DIVZERO;
      end
      default: begin
      end
    endcase
    if (cw.uop == pse_pkg::UOP_EMIT && !out_busy) begin
      top_value   <= (depth == '0) ? 32'sd0 : $signed(tos);
      stack_depth <= 5'(depth);
      status      <= st;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cw.uop == pse_pkg::UOP_WB_OP) begin
        depth <= depth - DW'(1);
      end else if (cw.uop == pse_pkg::UOP_PUSH) begin
        depth <= depth + DW'(1);
      end
      if (cw.uop == pse_pkg::UOP_EMIT && !out_busy) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/postfix_stack_evaluator_top.sv
// Postfix expression evaluator: each request carries one character. The
// characters + - * / % pop two values, combine them and push the result;
// any other character pushes its signed byte value minus 48. Each request
// yields one result with the new top value, the depth and a status, and an
// erroring request leaves the stack untouched. A small microcode program
// steps a shared datapath. A push checks for a full stack and then writes.
// An operator reads its left operand and checks for underflow and a zero
// divisor; add, subtract and multiply then use the ALU, while divide and
// remainder run the radix-2 divider, one quotient bit per cycle, and then
// fix the signs. The result is registered as the evaluator returns to wait
// for the next request, and that request can be taken while the previous
// result still waits at the output register; a new result then waits in
// its last step until the previous one has been taken.
module postfix_stack_evaluator_top #(
  parameter int STACK_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         symbol,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] top_value,
  output logic [4:0]         stack_depth,
  output logic [1:0]         status
);

  pse_pkg::ctrl_word_t cw;
  pse_pkg::flags_t     flags;
  logic                in_accept;

  assign in_stall  = (cw.uop != pse_pkg::UOP_FETCH);
  assign in_accept = in_valid && !in_stall;

  pse_useq u_useq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .flags    (flags),
    .cw       (cw)
  );

  pse_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cw          (cw),
    .in_accept   (in_accept),
    .symbol      (symbol),
    .flags       (flags),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .top_value   (top_value),
    .stack_depth (stack_depth),
    .status      (status)
  );

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int STACK_SIZE  = 16;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_WAIT  = 64;
  localparam int PHASE_ITEMS = 165;
  localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [31:0] top;
    logic [4:0]         depth;
    logic [1:0]         stat;
  } result_t;

  typedef struct packed {
    logic [7:0] sym;
    logic [4:0] reps;
    logic       fixed;
    result_t    res;
  } stim_row_t;

  localparam result_t NO_RES = '0;
  localparam int NUM_ROWS = 30;

  // Rows with fixed set carry a result that is known by hand; the rest are
  // checked against the predictor. The middle section builds the most
  // negative value, divides it by minus one, then takes the remainder.
  stim_row_t directed_rows [NUM_ROWS] = '{
    '{pse_pkg::CH_ADD,  5'd1,  1'b1, '{32'sd0, 5'd0, pse_pkg::ST_UNDERFLOW}},
    '{pse_pkg::CH_ZERO, 5'd1,  1'b1, '{32'sd0, 5'd1, pse_pkg::ST_OK}},
    '{pse_pkg::CH_ZERO, 5'd1,  1'b1, '{32'sd0, 5'd2, pse_pkg::ST_OK}},
    '{pse_pkg::CH_DIV,  5'd1,  1'b1, '{32'sd0, 5'd2, pse_pkg::ST_DIVZERO}},
    '{pse_pkg::CH_REM,  5'd1,  1'b1, '{32'sd0, 5'd2, pse_pkg::ST_DIVZERO}},
    '{pse_pkg::CH_ADD,  5'd1,  1'b1, '{32'sd0, 5'd1, pse_pkg::ST_OK}},
    '{8'hB0,            5'd1,  1'b1, '{-32'sd128, 5'd2, pse_pkg::ST_OK}},
    '{8'hB0,            5'd1,  1'b0, NO_RES},
    '{pse_pkg::CH_MUL,  5'd1,  1'b0, NO_RES},
    '{8'hB0,            5'd1,  1'b0, NO_RES},
    '{pse_pkg::CH_MUL,  5'd1,  1'b0, NO_RES},
    '{8'h70,            5'd1,  1'b0, NO_RES},
    '{pse_pkg::CH_MUL,  5'd1,  1'b0, NO_RES},
    '{8'h40,            5'd1,  1'b0, NO_RES},
    '{pse_pkg::CH_MUL,  5'd1,  1'b1, '{INT_MIN, 5'd2, pse_pkg::ST_OK}},
    '{pse_pkg::CH_ZERO, 5'd1,  1'b0, NO_RES},
    '{8'h31,            5'd1,  1'b0, NO_RES},
    '{pse_pkg::CH_SUB,  5'd1,  1'b1, '{-32'sd1, 5'd3, pse_pkg::ST_OK}},
    '{pse_pkg::CH_DIV,  5'd1,  1'b1, '{INT_MIN, 5'd2, pse_pkg::ST_OK}},
    '{pse_pkg::CH_ZERO, 5'd1,  1'b0, NO_RES},
    '{8'h31,            5'd1,  1'b0, NO_RES},
    '{pse_pkg::CH_SUB,  5'd1,  1'b0, NO_RES},
    '{pse_pkg::CH_REM,  5'd1,  1'b1, '{32'sd0, 5'd2, pse_pkg::ST_OK}},
    '{8'h00,            5'd1,  1'b1, '{-32'sd48, 5'd3, pse_pkg::ST_OK}},
    '{8'hFF,            5'd1,  1'b1, '{-32'sd49, 5'd4, pse_pkg::ST_OK}},
    '{8'h7F,            5'd1,  1'b1, '{32'sd79, 5'd5, pse_pkg::ST_OK}},
    '{8'h80,            5'd1,  1'b1, '{-32'sd176, 5'd6, pse_pkg::ST_OK}},
    '{8'h7A,            5'd10, 1'b0, NO_RES},
    '{pse_pkg::CH_ZERO, 5'd1,  1'b1, '{32'sd74, 5'd16, pse_pkg::ST_OVERFLOW}},
    '{pse_pkg::CH_SUB,  5'd1,  1'b0, NO_RES}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] symbol = 8'h00;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] top_value;
  logic [4:0] stack_depth;
  logic [1:0] status;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int error_count = 0;
  int cycle_count = 0;

  logic [31:0] stack_mem [STACK_SIZE];
  int unsigned stack_count = 0;
  result_t pending_results[$];

  always #10 clk = ~clk;

  postfix_stack_evaluator_top #(.STACK_DEPTH(STACK_SIZE)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .symbol(symbol),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .top_value(top_value),
    .stack_depth(stack_depth),
    .status(status)
  );

  task automatic report_mismatch(input string msg);
    $display("ERROR at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // Applies one symbol to the local copy of the stack and returns the result.
  function automatic result_t evaluate_symbol(input logic [7:0] sym);
    result_t r;
    logic signed [31:0] lhs;
    logic signed [31:0] rhs;
    logic signed [31:0] val;
    r.stat = pse_pkg::ST_OK;
    if (sym == pse_pkg::CH_ADD || sym == pse_pkg::CH_SUB || sym == pse_pkg::CH_MUL ||
        sym == pse_pkg::CH_DIV || sym == pse_pkg::CH_REM) begin
      if (stack_count < 2) begin
        r.stat = pse_pkg::ST_UNDERFLOW;
      end else begin
        lhs = stack_mem[stack_count - 2];
        rhs = stack_mem[stack_count - 1];
        if ((sym == pse_pkg::CH_DIV || sym == pse_pkg::CH_REM) && rhs == 0) begin
          r.stat = pse_pkg::ST_DIVZERO;
        end else begin
          case (sym)
            pse_pkg::CH_ADD: val = lhs + rhs;
            pse_pkg::CH_SUB: val = lhs - rhs;
            pse_pkg::CH_MUL: val = lhs * rhs;
            pse_pkg::CH_DIV: val = (lhs == INT_MIN && rhs == -1) ? INT_MIN : lhs / rhs;
            default:         val = (lhs == INT_MIN && rhs == -1) ? 32'sd0 : lhs % rhs;
          endcase
          stack_mem[stack_count - 2] = val;
          stack_count--;
        end
      end
    end else if (stack_count >= STACK_SIZE) begin
      r.stat = pse_pkg::ST_OVERFLOW;
    end else begin
      stack_mem[stack_count] = {{24{sym[7]}}, sym} - {24'd0, pse_pkg::CH_ZERO};
      stack_count++;
    end
    r.top = (stack_count != 0) ? stack_mem[stack_count - 1] : 32'sd0;
    r.depth = stack_count[4:0];
    return r;
  endfunction

  // Presents one request and waits for it to be taken. Valid is lowered only
  // when an idle gap follows, so back-to-back requests keep it high.
  task automatic send_request(input logic [7:0] sym, input logic fixed,
                              input result_t fixed_res);
    result_t predicted;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    symbol <= sym;
    do @(posedge clk); while (in_stall);
    predicted = evaluate_symbol(sym);
    pending_results.push_back(fixed ? fixed_res : predicted);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = pending_results.pop_front();
          if (top_value !== want.top)
            report_mismatch($sformatf("top_value got %0d expected %0d",
                                      top_value, want.top));
          if (stack_depth !== want.depth)
            report_mismatch($sformatf("stack_depth got %0d expected %0d",
                                      stack_depth, want.depth));
          if (status !== want.stat)
            report_mismatch($sformatf("status got %0d expected %0d",
                                      status, want.stat));
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    int push_pct;
    logic [7:0] sym;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < NUM_ROWS; i++) begin
      for (int k = 0; k < directed_rows[i].reps; k++)
        send_request(directed_rows[i].sym, directed_rows[i].fixed, directed_rows[i].res);
    end

    // Phases: no idling, sender idle, receiver stalling, then both.
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1) ? 87 : (phase == 3) ? 17 : 0;
      recv_stall_pct = (phase == 2) ? 87 : (phase == 3) ? 17 : 0;
      push_pct = 55;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // The push share moves around so the depth swings between empty and full.
        if (n % 40 == 0) push_pct = $urandom_range(75, 30);
        if ($urandom_range(99) < push_pct) begin
          case ($urandom_range(3))
            0: sym = pse_pkg::CH_ZERO + 8'($urandom_range(9));
            1: sym = pse_pkg::CH_ZERO;
            default: sym = 8'($urandom_range(255));
          endcase
        end else begin
          case ($urandom_range(4))
            0: sym = pse_pkg::CH_ADD;
            1: sym = pse_pkg::CH_SUB;
            2: sym = pse_pkg::CH_MUL;
            3: sym = pse_pkg::CH_DIV;
            default: sym = pse_pkg::CH_REM;
          endcase
        end
        send_request(sym, 1'b0, NO_RES);
      end
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
